// File: rtl/core/dvru_pkg.sv
package dvru_pkg;

   localparam int NODES_DEF   = 8;
   localparam int INF_DEF     = 65535;
   localparam int COST_W      = 16;
   localparam int NODE_W      = 3;
   localparam int MASK_W      = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;

   localparam logic FUNC_LINK   = 1'b0;
   localparam logic FUNC_VECTOR = 1'b1;

   localparam logic KIND_ROUTE  = 1'b0;
   localparam logic KIND_ADVERT = 1'b1;

   typedef struct packed {
      logic              func;
      logic [NODE_W-1:0] peer;
      logic [NODE_W-1:0] target;
      logic [COST_W-1:0] cost;
      logic              recompute;
      logic              peer_ok;
      logic              target_ok;
   } cmd_type;

   typedef struct packed {
      logic              kind;
      logic [NODE_W-1:0] dest;
      logic [NODE_W-1:0] next_hop;
      logic              no_route;
      logic [COST_W-1:0] route_cost;
      logic [MASK_W-1:0] neighbor_mask;
      logic              last;
   } rsp_type;

endpackage

// File: rtl/core/distance_vector_route_update_unit.sv
// Vector elements that do not end a vector: one request per cycle while the back is
// idle; each passes the front register and the queue before the neighbor table write.
// Recompute (link change or final element): the back walks the neighbor table
// through its single read port, then advertises every distance if one changed.
// Only changed destinations get a route update; a low rsp_tready stalls the walk.
// Reset: synchronous; after it a sweep loads all 2**(2*ceil(log2(NODES))) entries
// of the neighbor table (64 for 8 nodes) with req_tready low.
module distance_vector_route_update_unit #(
   parameter int NODES    = dvru_pkg::NODES_DEF,
   parameter int INF_COST = dvru_pkg::INF_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [dvru_pkg::NODE_W-1:0]        csr_wr_data,   // own_node
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dvru_pkg::REQ_DATA_W-1:0]    req_tdata,     // peer, target_node, cost_value
   input  logic                               req_tuser,     // func
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dvru_pkg::RSP_DATA_W-1:0]    rsp_tdata,     // dest, next_hop, no_route,
                                                             // route_cost, neighbor_mask
   output logic                               rsp_tuser,     // kind
   output logic                               rsp_tlast
);

   localparam int PadW = dvru_pkg::RSP_DATA_W - 2 * dvru_pkg::NODE_W - 1
                         - dvru_pkg::COST_W - dvru_pkg::MASK_W;

   logic [dvru_pkg::NODE_W-1:0] own_node_ff;
   logic                        clear_done;
   logic                        f_valid, f_ready, q_valid, q_ready;
   dvru_pkg::cmd_type           f_cmd, q_cmd;
   dvru_pkg::rsp_type           rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff <= '0;
      end else if (csr_wr_en) begin
         own_node_ff <= csr_wr_data;
      end
   end

   dvru_front #(.NODES(NODES), .INF_COST(INF_COST)) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept_en  (clear_done),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd)
   );

   dvru_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  (f_cmd),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_cmd)
   );

   dvru_back #(.NODES(NODES), .INF_COST(INF_COST)) u_back (
      .clock      (clock),
      .reset      (reset),
      .own_node   (own_node_ff),
      .clear_done (clear_done),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {{PadW{1'b0}}, rsp.neighbor_mask, rsp.route_cost, rsp.no_route,
                       rsp.next_hop, rsp.dest};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

// File: rtl/core/dvru_front.sv
module dvru_front #(
   parameter int NODES    = dvru_pkg::NODES_DEF,
   parameter int INF_COST = dvru_pkg::INF_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept_en,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dvru_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                cmd_valid,
   input  logic                                cmd_ready,
   output dvru_pkg::cmd_type                   cmd
);

   localparam logic [dvru_pkg::COST_W-1:0] Inf = dvru_pkg::COST_W'(INF_COST);

   logic                                  cmd_v_ff, cmd_v_in;
   dvru_pkg::cmd_type                     cmd_ff, cmd_in;
   logic [dvru_pkg::COST_W-1:0]           raw_cost;
   logic                                  req_take;

   assign req_tready = accept_en && (!cmd_v_ff || cmd_ready);
   assign req_take   = req_tvalid && req_tready;
   assign raw_cost   = req_tdata[2*dvru_pkg::NODE_W +: dvru_pkg::COST_W];

   always_comb begin
      cmd_in.func      = req_tuser;
      cmd_in.peer      = req_tdata[dvru_pkg::NODE_W-1:0];
      cmd_in.target    = req_tdata[dvru_pkg::NODE_W +: dvru_pkg::NODE_W];
      cmd_in.cost      = (raw_cost >= Inf) ? Inf : raw_cost;
      cmd_in.recompute = (req_tuser == dvru_pkg::FUNC_LINK) || req_tlast;
      cmd_in.peer_ok   = 32'(cmd_in.peer) < NODES;
      cmd_in.target_ok = 32'(cmd_in.target) < NODES;
   end

   always_comb begin
      cmd_v_in = cmd_v_ff;
      if (req_take) begin
         cmd_v_in = 1'b1;
      end else if (cmd_ready) begin
         cmd_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_v_ff <= 1'b0;
      end else begin
         cmd_v_ff <= cmd_v_in;
      end
      if (req_take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = cmd_v_ff;
   assign cmd       = cmd_ff;

endmodule

// File: rtl/core/dvru_fifo.sv
module dvru_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  dvru_pkg::cmd_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output dvru_pkg::cmd_type rd_data
);

   localparam int PtrW = (dvru_pkg::QUEUE_DEPTH > 1) ? $clog2(dvru_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(dvru_pkg::QUEUE_DEPTH + 1);

   dvru_pkg::cmd_type slot_ff [dvru_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              push, pop;

   assign wr_ready = count_ff != CntW'(dvru_pkg::QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(dvru_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(dvru_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/core/dvru_back.sv
module dvru_back #(
   parameter int NODES    = dvru_pkg::NODES_DEF,
   parameter int INF_COST = dvru_pkg::INF_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [dvru_pkg::NODE_W-1:0]  own_node,
   output logic                         clear_done,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  dvru_pkg::cmd_type            cmd,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output dvru_pkg::rsp_type            rsp
);

   localparam int TW       = $clog2(NODES);
   localparam int StepW    = $clog2(NODES + 1);
   localparam int AW       = 2 * TW;
   localparam int MemDepth = 1 << AW;
   localparam int CW       = dvru_pkg::COST_W;
   localparam logic [CW-1:0] Inf = CW'(INF_COST);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_RUN   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_ADV   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic [TW-1:0]    t_ff, t_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             changed_ff, changed_in;

   logic             c_v_ff, c_first_ff, c_last_ff;
   logic [TW-1:0]    c_t_ff, c_node_ff;
   logic [CW-1:0]    c_lc_ff;
   logic [CW-1:0]    best_ff;
   logic [TW-1:0]    hop_ff;
   logic             none_ff;
   logic             fin_v_ff;
   logic [TW-1:0]    fin_t_ff, fin_hop_ff;
   logic [CW-1:0]    fin_best_ff;
   logic             fin_none_ff;

   logic [CW-1:0]    nv_mem [MemDepth];
   logic [CW-1:0]    rd_ff;
   logic [CW-1:0]    link_ff [NODES];
   logic [CW-1:0]    dist_ff [NODES];

   logic              out_v_ff, out_v_in;
   dvru_pkg::rsp_type out_ff, out_in;

   logic             en, own_ok, issue, pop;
   logic [TW-1:0]    own_idx, lc_addr, step_node, dist_addr;
   logic [CW-1:0]    lc_rd, dist_rd, total, best_nx;
   logic [CW:0]      sum;
   logic [TW-1:0]    hop_nx;
   logic             none_nx, cand, fin_emit, adv_emit;
   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_wa, mem_ra;
   logic [CW-1:0]    mem_wd;
   logic [dvru_pkg::MASK_W-1:0] mask;

   assign en         = !out_v_ff || rsp_ready;
   assign own_ok     = 32'(own_node) < NODES;
   assign own_idx    = TW'(own_node);
   assign clear_done = state_ff != S_CLEAR;
   assign cmd_ready  = state_ff == S_IDLE;
   assign pop        = cmd_valid && cmd_ready;
   assign issue      = (state_ff == S_RUN) && en;
   assign step_node  = TW'(step_ff - StepW'(1));
   assign lc_addr    = (step_ff == '0) ? t_ff : step_node;
   assign lc_rd      = link_ff[lc_addr];
   assign dist_addr  = (state_ff == S_ADV) ? t_ff : fin_t_ff;
   assign dist_rd    = dist_ff[dist_addr];

   always_comb begin
      mem_we = 1'b0;
      mem_wa = clr_ff;
      mem_wd = (clr_ff[AW-1:TW] == clr_ff[TW-1:0]) ? '0 : Inf;
      if (state_ff == S_CLEAR) begin
         mem_we = 1'b1;
      end else if (pop) begin
         if (cmd.func == dvru_pkg::FUNC_LINK) begin
            mem_we = cmd.peer_ok && own_ok;
            mem_wa = {own_idx, TW'(cmd.peer)};
         end else begin
            mem_we = cmd.peer_ok && cmd.target_ok;
            mem_wa = {TW'(cmd.peer), TW'(cmd.target)};
         end
         mem_wd = cmd.cost;
      end
   end

   assign mem_re = issue && (step_ff != '0);
   assign mem_ra = {step_node, t_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         nv_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= nv_mem[mem_ra];
      end
   end

   assign sum   = {1'b0, c_lc_ff} + {1'b0, rd_ff};
   assign total = (sum >= {1'b0, Inf}) ? Inf : sum[CW-1:0];
   assign cand  = !c_first_ff && (c_lc_ff < Inf) && !(own_ok && (c_node_ff == own_idx))
                  && (total < best_ff);

   always_comb begin
      best_nx = best_ff;
      hop_nx  = hop_ff;
      none_nx = none_ff;
      if (c_first_ff) begin
         best_nx = c_lc_ff;
         hop_nx  = c_t_ff;
         none_nx = c_lc_ff >= Inf;
      end else if (cand) begin
         best_nx = total;
         hop_nx  = c_node_ff;
         none_nx = 1'b0;
      end
   end

   assign fin_emit = en && fin_v_ff && !(own_ok && (fin_t_ff == own_idx))
                     && (fin_best_ff != dist_rd);
   assign adv_emit = en && (state_ff == S_ADV);

   for (genvar i = 0; i < dvru_pkg::MASK_W; i++) begin : g_mask
      if (i < NODES) begin : g_node
         assign mask[i] = (link_ff[i] < Inf) && !(own_ok && (32'(own_node) == i));
      end else begin : g_none
         assign mask[i] = 1'b0;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      t_in       = t_ff;
      step_in    = step_ff;
      changed_in = changed_ff;
      if (fin_emit) begin
         changed_in = 1'b1;
      end
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (pop && cmd.recompute) begin
               state_in   = S_RUN;
               t_in       = '0;
               step_in    = '0;
               changed_in = 1'b0;
            end
         end
         S_RUN: begin
            if (en) begin
               step_in = step_ff + 1'b1;
               if (step_ff == StepW'(NODES)) begin
                  step_in = '0;
                  t_in    = t_ff + 1'b1;
                  if (t_ff == TW'(NODES - 1)) begin
                     t_in     = '0;
                     state_in = S_DRAIN;
                  end
               end
            end
         end
         S_DRAIN: begin
            if (en && !c_v_ff && !fin_v_ff) begin
               t_in     = '0;
               state_in = changed_ff ? S_ADV : S_IDLE;
            end
         end
         S_ADV: begin
            if (en) begin
               t_in = t_ff + 1'b1;
               if (t_ff == TW'(NODES - 1)) begin
                  t_in     = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_in   = out_ff;
      out_v_in = out_v_ff;
      if (fin_emit) begin
         out_v_in             = 1'b1;
         out_in.kind          = dvru_pkg::KIND_ROUTE;
         out_in.dest          = dvru_pkg::NODE_W'(fin_t_ff);
         out_in.next_hop      = fin_none_ff ? '0 : dvru_pkg::NODE_W'(fin_hop_ff);
         out_in.no_route      = fin_none_ff;
         out_in.route_cost    = fin_best_ff;
         out_in.neighbor_mask = '0;
         out_in.last          = 1'b0;
      end else if (adv_emit) begin
         out_v_in             = 1'b1;
         out_in.kind          = dvru_pkg::KIND_ADVERT;
         out_in.dest          = dvru_pkg::NODE_W'(t_ff);
         out_in.next_hop      = '0;
         out_in.no_route      = 1'b0;
         out_in.route_cost    = dist_rd;
         out_in.neighbor_mask = mask;
         out_in.last          = t_ff == TW'(NODES - 1);
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         t_ff       <= '0;
         step_ff    <= '0;
         changed_ff <= 1'b0;
         c_v_ff     <= 1'b0;
         fin_v_ff   <= 1'b0;
         out_v_ff   <= 1'b0;
         for (int i = 0; i < NODES; i++) begin
            link_ff[i] <= Inf;
            dist_ff[i] <= (i == 0) ? '0 : Inf;
         end
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         t_ff       <= t_in;
         step_ff    <= step_in;
         changed_ff <= changed_in;
         out_v_ff   <= out_v_in;
         if (en) begin
            c_v_ff   <= issue;
            fin_v_ff <= c_v_ff && c_last_ff;
         end
         if (pop && (cmd.func == dvru_pkg::FUNC_LINK) && cmd.peer_ok) begin
            link_ff[TW'(cmd.peer)] <= cmd.cost;
         end
         if (fin_emit) begin
            dist_ff[fin_t_ff] <= fin_best_ff;
         end
      end
      out_ff <= out_in;
      if (issue) begin
         c_first_ff <= step_ff == '0;
         c_last_ff  <= step_ff == StepW'(NODES);
         c_t_ff     <= t_ff;
         c_node_ff  <= step_node;
         c_lc_ff    <= lc_rd;
      end
      if (en && c_v_ff) begin
         best_ff <= best_nx;
         hop_ff  <= hop_nx;
         none_ff <= none_nx;
         if (c_last_ff) begin
            fin_t_ff    <= c_t_ff;
            fin_best_ff <= best_nx;
            fin_hop_ff  <= hop_nx;
            fin_none_ff <= none_nx;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp       = out_ff;

endmodule

// File: rtl/core/dvru_checker.sv
module dvru_checker #(
   parameter int INF_COST = dvru_pkg::INF_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dvru_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);

   localparam logic [dvru_pkg::COST_W-1:0] Inf = dvru_pkg::COST_W'(INF_COST);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_sweep_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during table sweep");

   a_last_is_advert: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == dvru_pkg::KIND_ADVERT)
      else $error("final response is not an advertisement");

   a_no_route: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == dvru_pkg::KIND_ROUTE) && rsp_tdata[6]
         |-> (rsp_tdata[5:3] == '0) && (rsp_tdata[22:7] == Inf))
      else $error("unreachable route with hop or finite cost");

   a_advert_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == dvru_pkg::KIND_ADVERT) |-> rsp_tdata[6:3] == '0)
      else $error("advertisement carries hop or no-route flag");

endmodule

bind distance_vector_route_update_unit dvru_checker #(.INF_COST(INF_COST)) u_dvru_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int NODE_COUNT = dvru_pkg::NODES_DEF;
   localparam logic [dvru_pkg::COST_W-1:0] NO_PATH = dvru_pkg::COST_W'(dvru_pkg::INF_DEF);
   localparam int SETTLE_CYCLES = 1000;

   typedef struct packed {
      logic                        func;
      logic [dvru_pkg::NODE_W-1:0] peer;
      logic [dvru_pkg::NODE_W-1:0] target;
      logic [dvru_pkg::COST_W-1:0] cost;
      logic                        closes;
   } route_req_type;

   class route_board_type;
      logic [dvru_pkg::NODE_W-1:0] self_id;
      logic [dvru_pkg::COST_W-1:0] own_dist[NODE_COUNT];
      logic [dvru_pkg::COST_W-1:0] heard_cost[NODE_COUNT][NODE_COUNT];
      logic [dvru_pkg::COST_W-1:0] direct_cost[NODE_COUNT];
      dvru_pkg::rsp_type           awaited[$];
      int                          mismatches;
      int                          requests;
      int                          routes;
      int                          adverts;

      function new();
         self_id = '0;
         mismatches = 0;
         requests = 0;
         routes = 0;
         adverts = 0;
         for (int i = 0; i < NODE_COUNT; i++) begin
            own_dist[i] = NO_PATH;
            direct_cost[i] = NO_PATH;
            for (int j = 0; j < NODE_COUNT; j++)
               heard_cost[i][j] = (i == j) ? '0 : NO_PATH;
         end
         own_dist[0] = '0;
      endfunction

      function void relax_routes();
         dvru_pkg::rsp_type           batch[$];
         dvru_pkg::rsp_type           item;
         logic [dvru_pkg::COST_W-1:0] best;
         logic [dvru_pkg::COST_W-1:0] total;
         logic [dvru_pkg::COST_W:0]   sum;
         int                          hop;
         bit                          unreach;
         logic [dvru_pkg::MASK_W-1:0] mask;
         for (int t = 0; t < NODE_COUNT; t++) begin
            if (t != self_id) begin
               best = direct_cost[t];
               hop = t;
               unreach = (best == NO_PATH);
               for (int v = 0; v < NODE_COUNT; v++) begin
                  if (v != self_id && direct_cost[v] != NO_PATH) begin
                     sum = {1'b0, direct_cost[v]} + {1'b0, heard_cost[v][t]};
                     total = (sum >= {1'b0, NO_PATH}) ? NO_PATH
                                                      : sum[dvru_pkg::COST_W-1:0];
                     if (total < best) begin
                        best = total;
                        hop = v;
                        unreach = 1'b0;
                     end
                  end
               end
               if (best != own_dist[t]) begin
                  own_dist[t] = best;
                  item = '0;
                  item.kind = dvru_pkg::KIND_ROUTE;
                  item.dest = dvru_pkg::NODE_W'(t);
                  item.next_hop = unreach ? '0 : dvru_pkg::NODE_W'(hop);
                  item.no_route = unreach;
                  item.route_cost = best;
                  batch.push_back(item);
               end
            end
         end
         if (batch.size() > 0) begin
            mask = '0;
            for (int v = 0; v < NODE_COUNT; v++)
               if (v != self_id && direct_cost[v] != NO_PATH)
                  mask[v] = 1'b1;
            for (int t = 0; t < NODE_COUNT; t++) begin
               item = '0;
               item.kind = dvru_pkg::KIND_ADVERT;
               item.dest = dvru_pkg::NODE_W'(t);
               item.route_cost = own_dist[t];
               item.neighbor_mask = mask;
               batch.push_back(item);
            end
            batch[batch.size()-1].last = 1'b1;
         end
         foreach (batch[i])
            awaited.push_back(batch[i]);
      endfunction

      function void note_request(route_req_type r);
         requests++;
         if (r.func == dvru_pkg::FUNC_LINK) begin
            direct_cost[r.peer] = r.cost;
            heard_cost[self_id][r.peer] = r.cost;
            relax_routes();
         end else begin
            heard_cost[r.peer][r.target] = r.cost;
            if (r.closes)
               relax_routes();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(dvru_pkg::rsp_type got);
         dvru_pkg::rsp_type want;
         if (awaited.size() == 0) begin
            $error("response with nothing pending: kind %0d dest %0d cost %0d",
                   got.kind, got.dest, got.route_cost);
            mismatches++;
         end else begin
            want = awaited.pop_front();
            if (want.kind == dvru_pkg::KIND_ROUTE)
               routes++;
            else
               adverts++;
            compare_field("kind", want.kind, got.kind);
            compare_field("dest", want.dest, got.dest);
            compare_field("next_hop", want.next_hop, got.next_hop);
            compare_field("no_route", want.no_route, got.no_route);
            compare_field("route_cost", want.route_cost, got.route_cost);
            compare_field("neighbor_mask", want.neighbor_mask, got.neighbor_mask);
            compare_field("last", want.last, got.last);
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_wr_en = 1'b0;
   logic [dvru_pkg::NODE_W-1:0]     csr_wr_data = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [dvru_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [dvru_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;

   route_board_type board;
   int              burst_left = 0;
   bit              gaps_on = 1'b1;
   int              node_ids_used = 0;
   int              stall_left = 0;
   int              mode_left = 0;
   int              rx_mode = 0;

   distance_vector_route_update_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      route_req_type seen;
      if (!reset && req_tvalid && req_tready) begin
         seen.func = req_tuser;
         seen.peer = req_tdata[2:0];
         seen.target = req_tdata[5:3];
         seen.cost = req_tdata[21:6];
         seen.closes = req_tlast;
         board.note_request(seen);
      end
   end

   always @(posedge clock) begin
      dvru_pkg::rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.dest = rsp_tdata[2:0];
         got.next_hop = rsp_tdata[5:3];
         got.no_route = rsp_tdata[6];
         got.route_cost = rsp_tdata[22:7];
         got.neighbor_mask = rsp_tdata[30:23];
         got.last = rsp_tlast;
         board.check_response(got);
      end
   end

   always @(negedge clock) begin
      if (mode_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 3) == 0)
                  stall_left = $urandom_range(1, 40);
            end
         end
      endcase
   end

   function automatic logic [dvru_pkg::COST_W-1:0] pick_cost();
      case ($urandom_range(0, 11))
         0: return NO_PATH;
         1: return '0;
         2: return dvru_pkg::COST_W'($urandom);
         3: return NO_PATH - 1'b1;
         default: return dvru_pkg::COST_W'($urandom_range(1, 40));
      endcase
   endfunction

   task automatic pause_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
   endtask

   task automatic send_request(route_req_type r);
      if (burst_left == 0) begin
         if (gaps_on)
            pause_sender($urandom_range(1, 8));
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = r.func;
      req_tlast = r.closes;
      req_tdata = {2'b00, r.cost, r.target, r.peer};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_item(logic func, int peer, int target,
                            logic [dvru_pkg::COST_W-1:0] cost, logic closes);
      route_req_type r;
      r.func = func;
      r.peer = dvru_pkg::NODE_W'(peer);
      r.target = dvru_pkg::NODE_W'(target);
      r.cost = cost;
      r.closes = closes;
      send_request(r);
   endtask

   task automatic wait_drained();
      pause_sender(1);
      while (board.awaited.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_own_node(logic [dvru_pkg::NODE_W-1:0] id);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = id;
      @(negedge clock);
      csr_wr_en = 1'b0;
      board.self_id = id;
      node_ids_used++;
   endtask

   task automatic run_random(int quota);
      route_req_type r;
      int            sent;
      int            len;
      int            peer;
      int            pick;
      bit            full;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            do peer = $urandom_range(0, NODE_COUNT - 1); while (peer == board.self_id);
            full = ($urandom_range(0, 2) == 0);
            len = full ? NODE_COUNT : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               r.func = dvru_pkg::FUNC_VECTOR;
               r.peer = dvru_pkg::NODE_W'(peer);
               r.target = full ? dvru_pkg::NODE_W'(i)
                               : dvru_pkg::NODE_W'($urandom_range(0, NODE_COUNT - 1));
               r.cost = pick_cost();
               r.closes = (i == len - 1);
               send_request(r);
               sent++;
            end
         end else begin
            r.func = (pick < 9) ? dvru_pkg::FUNC_LINK : dvru_pkg::FUNC_VECTOR;
            r.peer = dvru_pkg::NODE_W'($urandom_range(0, NODE_COUNT - 1));
            r.target = dvru_pkg::NODE_W'($urandom_range(0, NODE_COUNT - 1));
            r.cost = pick_cost();
            r.closes = 1'($urandom_range(0, 1));
            send_request(r);
            sent++;
         end
      end
   endtask

   initial begin
      logic [dvru_pkg::NODE_W-1:0] phase_ids[4];
      board = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      set_own_node(3'd0);

      // direct link, repeat with no change, link to self
      send_item(dvru_pkg::FUNC_LINK, 1, 0, 16'd10, 1'b0);
      send_item(dvru_pkg::FUNC_LINK, 1, 5, 16'd10, 1'b1);
      send_item(dvru_pkg::FUNC_LINK, 0, 0, 16'd7, 1'b0);
      // vector from neighbor 1, zero and infinite elements
      send_item(dvru_pkg::FUNC_VECTOR, 1, 2, 16'd5, 1'b0);
      send_item(dvru_pkg::FUNC_VECTOR, 1, 3, NO_PATH, 1'b0);
      send_item(dvru_pkg::FUNC_VECTOR, 1, 4, 16'd0, 1'b1);
      // equal paths through neighbors 1 and 2
      send_item(dvru_pkg::FUNC_VECTOR, 2, 6, 16'd5, 1'b0);
      send_item(dvru_pkg::FUNC_LINK, 2, 0, 16'd15, 1'b0);
      send_item(dvru_pkg::FUNC_VECTOR, 1, 6, 16'd10, 1'b1);
      // direct link against an equal path
      send_item(dvru_pkg::FUNC_VECTOR, 1, 7, 16'd30, 1'b1);
      send_item(dvru_pkg::FUNC_LINK, 7, 0, 16'd20, 1'b0);
      send_item(dvru_pkg::FUNC_VECTOR, 1, 7, 16'd10, 1'b1);
      // saturate at infinity, zero link cost
      send_item(dvru_pkg::FUNC_LINK, 3, 0, NO_PATH - 1'b1, 1'b0);
      send_item(dvru_pkg::FUNC_VECTOR, 3, 5, 16'd100, 1'b1);
      send_item(dvru_pkg::FUNC_LINK, 4, 0, 16'd0, 1'b0);
      send_item(dvru_pkg::FUNC_VECTOR, 4, 5, NO_PATH, 1'b1);
      // drop every link, ending with an empty neighbor mask
      send_item(dvru_pkg::FUNC_LINK, 1, 0, NO_PATH, 1'b0);
      send_item(dvru_pkg::FUNC_LINK, 2, 0, NO_PATH, 1'b0);
      send_item(dvru_pkg::FUNC_LINK, 3, 0, NO_PATH, 1'b0);
      send_item(dvru_pkg::FUNC_LINK, 4, 0, NO_PATH, 1'b0);
      send_item(dvru_pkg::FUNC_LINK, 7, 0, NO_PATH, 1'b0);
      wait_drained();

      phase_ids[0] = 3'd7;
      phase_ids[1] = dvru_pkg::NODE_W'($urandom_range(1, 6));
      phase_ids[2] = 3'd0;
      phase_ids[3] = 3'd4;
      for (int p = 0; p < 4; p++) begin
         set_own_node(phase_ids[p]);
         gaps_on = (p != 2);
         run_random(44);
         wait_drained();
         run_random(44);
         wait_drained();
      end

      $display("tb: %0d requests over %0d node ids; %0d route updates, %0d advertised elements",
               board.requests, node_ids_used, board.routes, board.adverts);
      $display("tb: %0d mismatches", board.mismatches);
      if (board.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: distance_vector_route_update_unit.f
rtl/core/dvru_pkg.sv
rtl/core/dvru_front.sv
rtl/core/dvru_fifo.sv
rtl/core/dvru_back.sv
rtl/core/distance_vector_route_update_unit.sv
rtl/core/dvru_checker.sv
sim/testbench.sv
